>>> rtl/dpc_pkg.sv
// Shared types and constants for the distance peak centroid block.
package dpc_pkg;

   // Field widths fixed by the pixel and result formats.
   localparam int DIST_W    = 16;
   localparam int COORD_W   = 10;
   localparam int COUNT_W   = 21;
   localparam int SUM_W     = 30;
   // One quotient bit per divide step.
   localparam int DIV_STEPS = SUM_W;

   // One pixel beat.
   typedef struct packed {
      logic [DIST_W-1:0]  distance_value;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               frame_last;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [DIST_W-1:0]  radius;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // take in the pixel on the request port
      logic div_load;   // latch totals into the divider and clear accumulators
      logic div_step;   // run one restoring divide step
      logic out_load;   // capture quotients into the result register
   } dpc_cmd_type;

endpackage

>>> rtl/dpc_datapath.sv
// Datapath: peak and tie accumulators, serial divider and result register.
module dpc_datapath #(
   parameter int VALUE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dpc_pkg::req_type     req_data,
   input  dpc_pkg::dpc_cmd_type cmd,
   output dpc_pkg::rsp_type     rsp_data
);
   import dpc_pkg::*;

   localparam int PEAK_W = (VALUE_BITS < DIST_W) ? VALUE_BITS : DIST_W;

   typedef struct packed {
      logic [COUNT_W-1:0] rem;
      logic [SUM_W-1:0]   quo;
   } div_state_type;

   // One restoring divide step: shift in the next dividend bit, try a subtract.
   function automatic div_state_type div_iter(input div_state_type cur,
                                              input logic [COUNT_W-1:0] divisor);
      logic [COUNT_W:0]   trial;
      logic [COUNT_W+1:0] diff;
      div_state_type      nxt;
      trial = {cur.rem, cur.quo[SUM_W-1]};
      diff  = {1'b0, trial} - {2'b00, divisor};
      if (diff[COUNT_W+1]) begin
         nxt.rem = trial[COUNT_W-1:0];
      end else begin
         nxt.rem = diff[COUNT_W-1:0];
      end
      nxt.quo = {cur.quo[SUM_W-2:0], ~diff[COUNT_W+1]};
      return nxt;
   endfunction

   logic [PEAK_W-1:0]  peak_ff, peak_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]   xsum_ff, xsum_in;
   logic [SUM_W-1:0]   ysum_ff, ysum_in;

   logic [PEAK_W-1:0]  peak_upd;
   logic [COUNT_W-1:0] count_upd;
   logic [SUM_W-1:0]   xsum_upd, ysum_upd;
   logic [SUM_W:0]     xsum_wide, ysum_wide;
   logic [PEAK_W-1:0]  value;

   logic [COUNT_W-1:0] divisor_ff, divisor_in;
   div_state_type      xdiv_ff, xdiv_in, ydiv_ff, ydiv_in;
   logic [PEAK_W-1:0]  radius_ff, radius_in;
   rsp_type            rsp_ff, rsp_in;

   // Peak compare and saturating tie-group update for the incoming pixel.
   always_comb begin
      value     = req_data.distance_value[PEAK_W-1:0];
      xsum_wide = {1'b0, xsum_ff} + (SUM_W+1)'(req_data.pixel_x);
      ysum_wide = {1'b0, ysum_ff} + (SUM_W+1)'(req_data.pixel_y);
      priority if (value > peak_ff) begin
         peak_upd  = value;
         count_upd = COUNT_W'(1);
         xsum_upd  = SUM_W'(req_data.pixel_x);
         ysum_upd  = SUM_W'(req_data.pixel_y);
      end else if (value == peak_ff) begin
         peak_upd  = peak_ff;
         count_upd = (&count_ff) ? count_ff : count_ff + COUNT_W'(1);
         xsum_upd  = xsum_wide[SUM_W] ? '1 : xsum_wide[SUM_W-1:0];
         ysum_upd  = ysum_wide[SUM_W] ? '1 : ysum_wide[SUM_W-1:0];
      end else begin
         peak_upd  = peak_ff;
         count_upd = count_ff;
         xsum_upd  = xsum_ff;
         ysum_upd  = ysum_ff;
      end
   end

   // Accumulators: updated per accepted pixel, cleared after the last one.
   always_comb begin
      peak_in  = peak_ff;
      count_in = count_ff;
      xsum_in  = xsum_ff;
      ysum_in  = ysum_ff;
      if (cmd.accept) begin
         if (req_data.frame_last) begin
            peak_in  = '0;
            count_in = '0;
            xsum_in  = '0;
            ysum_in  = '0;
         end else begin
            peak_in  = peak_upd;
            count_in = count_upd;
            xsum_in  = xsum_upd;
            ysum_in  = ysum_upd;
         end
      end
   end

   // Divider: both means share one divisor and step together.
   always_comb begin
      divisor_in = divisor_ff;
      xdiv_in    = xdiv_ff;
      ydiv_in    = ydiv_ff;
      radius_in  = radius_ff;
      if (cmd.div_load) begin
         divisor_in  = count_upd;
         xdiv_in.rem = '0;
         xdiv_in.quo = xsum_upd;
         ydiv_in.rem = '0;
         ydiv_in.quo = ysum_upd;
         radius_in   = peak_upd;
      end else if (cmd.div_step) begin
         xdiv_in = div_iter(xdiv_ff, divisor_ff);
         ydiv_in = div_iter(ydiv_ff, divisor_ff);
      end
   end

   // Result register; a zero count yields a zero center.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.out_load) begin
         rsp_in.center_x = (divisor_ff == '0) ? '0 : xdiv_ff.quo[COORD_W-1:0];
         rsp_in.center_y = (divisor_ff == '0) ? '0 : ydiv_ff.quo[COORD_W-1:0];
         rsp_in.radius   = DIST_W'(radius_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff  <= '0;
         count_ff <= '0;
         xsum_ff  <= '0;
         ysum_ff  <= '0;
      end else begin
         peak_ff  <= peak_in;
         count_ff <= count_in;
         xsum_ff  <= xsum_in;
         ysum_ff  <= ysum_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      xdiv_ff    <= xdiv_in;
      ydiv_ff    <= ydiv_in;
      radius_ff  <= radius_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/dpc_controller.sv
// Controller: sequences accumulate, divide and result hand-off.
module dpc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dpc_pkg::dpc_cmd_type cmd
);
   import dpc_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ST_ACCUM,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign req_ready = (state_ff == ST_ACCUM);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Commands follow the state and the handshakes.
   always_comb begin
      cmd          = '0;
      cmd.accept   = req_ready && req_valid;
      cmd.div_load = cmd.accept && req_last;
      cmd.div_step = (state_ff == ST_DIVIDE);
      cmd.out_load = (state_ff == ST_WRITE) && out_free;
   end

   // Next state, step count and result valid flag.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_ACCUM: begin
            if (cmd.div_load) begin
               state_in = ST_DIVIDE;
               step_in  = '0;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/distance_peak_centroid_top.sv
// Top level of the distance peak centroid block.
// Finds the peak of a distance map streamed one pixel per beat and reports the
// truncated mean column and row of all pixels holding that peak, plus the peak
// itself as the radius. Pixels of a frame are taken at one per clock. After
// the beat marked frame_last, req_ready drops while a 30-step restoring
// divider (one quotient bit per clock, both coordinates in parallel) forms
// the means and the result register is then loaded. If the previous result
// has not yet been taken, the block waits in its write state until the
// result register frees. A result waiting on rsp_ready does not block the
// pixels of the next frame. Counts and sums saturate on very large frames;
// only the low VALUE_BITS bits of the distance are compared.
module distance_peak_centroid_top #(
   parameter int VALUE_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dpc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dpc_pkg::rsp_type rsp_data
);
   import dpc_pkg::*;

   dpc_cmd_type cmd;

   dpc_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.frame_last),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dpc_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule

>>> rtl/dpc_checker.sv
// Port-level checker for the distance peak centroid block, with its bind.
module dpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input dpc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input dpc_pkg::rsp_type rsp_data
);
   import dpc_pkg::*;

   // A result beat stays offered until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // The pixel port closes while the means are being divided.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.frame_last |=> !req_ready)
      else $error("pixel accepted during the divide");

   // With the result register free, a frame end yields a result after the divide.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.frame_last && !rsp_valid
      |-> ##(DIV_STEPS + 1) !rsp_valid ##1 rsp_valid)
      else $error("result beat not produced on schedule");

   // A new result appears only as the divide finishes, with the pixel port closed.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result beat appeared outside the divide sequence");

endmodule

bind distance_peak_centroid_top dpc_checker u_dpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/tb.sv
// Self-checking testbench for the distance peak centroid block.
`timescale 1ns / 100ps

module tb;
   import dpc_pkg::*;

   localparam int VALUE_BITS = 16;
   localparam logic [DIST_W-1:0] VALUE_MASK = DIST_W'((64'd1 << VALUE_BITS) - 1);
   localparam int DIRECTED_ROWS = 17;
   localparam int RANDOM_PIXELS = 1200;
   localparam int QUIET_FROM = 1050;
   localparam int HOLD_AT = 400;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;

   // One directed row: the pixel beat and, where obvious, the result it closes.
   typedef struct packed {
      req_type px;
      logic    typed;
      rsp_type want;
   } probe_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Running peak, tie count and coordinate sums of the frame in progress.
   logic [DIST_W-1:0]  peak_now;
   logic [COUNT_W-1:0] tie_total;
   logic [SUM_W-1:0]   x_total;
   logic [SUM_W-1:0]   y_total;

   rsp_type       centers_due[$];
   probe_row_type probes[DIRECTED_ROWS];
   int            error_count;
   int            pixels_sent;
   bit            idle_on;
   bit            hold_request;
   int            hold_left;
   int            stall_left;

   distance_peak_centroid_top #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #20_000_000;
      $display("tb: errors");
      $finish;
   end

   task automatic flag_error(input string what);
      $display("tb: mismatch: %s", what);
      error_count++;
   endtask

   function automatic probe_row_type mk(input logic [DIST_W-1:0] value, input int x,
                                        input int y, input bit last, input bit typed,
                                        input int cx, input int cy,
                                        input logic [DIST_W-1:0] rad);
      probe_row_type r;
      r.px.distance_value = value;
      r.px.pixel_x = COORD_W'(x);
      r.px.pixel_y = COORD_W'(y);
      r.px.frame_last = last;
      r.typed = typed;
      r.want.center_x = COORD_W'(cx);
      r.want.center_y = COORD_W'(cy);
      r.want.radius = rad;
      return r;
   endfunction

   // Fold one accepted pixel into the running frame; on the last pixel, form
   // the truncated means and clear for the next frame.
   function automatic bit fold_pixel(input req_type px, output rsp_type center);
      logic [DIST_W-1:0] level;
      logic [COUNT_W:0]  n_next;
      logic [SUM_W:0]    x_next;
      logic [SUM_W:0]    y_next;
      level = px.distance_value & VALUE_MASK;
      n_next = {1'b0, tie_total} + (COUNT_W+1)'(1);
      x_next = {1'b0, x_total} + (SUM_W+1)'(px.pixel_x);
      y_next = {1'b0, y_total} + (SUM_W+1)'(px.pixel_y);
      center = '0;
      if (level > peak_now) begin
         peak_now = level;
         tie_total = COUNT_W'(1);
         x_total = SUM_W'(px.pixel_x);
         y_total = SUM_W'(px.pixel_y);
      end else if (level == peak_now) begin
         // Counts and sums stick at all ones on oversized frames.
         tie_total = n_next[COUNT_W] ? '1 : n_next[COUNT_W-1:0];
         x_total = x_next[SUM_W] ? '1 : x_next[SUM_W-1:0];
         y_total = y_next[SUM_W] ? '1 : y_next[SUM_W-1:0];
      end
      if (!px.frame_last) begin
         return 1'b0;
      end
      if (tie_total != 0) begin
         center.center_x = COORD_W'(x_total / tie_total);
         center.center_y = COORD_W'(y_total / tie_total);
      end
      center.radius = peak_now;
      peak_now = '0;
      tie_total = '0;
      x_total = '0;
      y_total = '0;
      return 1'b1;
   endfunction

   // Offer one pixel beat, after an optional gap, and hold it until taken.
   task automatic send_pixel(input req_type px, input bit typed, input rsp_type want);
      rsp_type center;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pixels_sent++;
      if (fold_pixel(px, center)) begin
         centers_due.push_back(typed ? want : center);
      end
   endtask

   // A random frame: values drawn mostly from three per-frame levels so that
   // ties, restarts and ignored pixels all occur.
   task automatic send_frame();
      logic [DIST_W-1:0] picks[3];
      int                len;
      req_type           px;
      for (int k = 0; k < 3; k++) begin
         picks[k] = DIST_W'($urandom);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         px.distance_value = ($urandom_range(0, 9) == 0) ? DIST_W'($urandom)
                                                         : picks[$urandom_range(0, 2)];
         px.pixel_x = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                                  : COORD_W'($urandom);
         px.pixel_y = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                                  : COORD_W'($urandom);
         px.frame_last = (i == len - 1);
         send_pixel(px, 1'b0, '0);
      end
   endtask

   task automatic check_center(input rsp_type got);
      rsp_type want;
      if (centers_due.size() == 0) begin
         flag_error($sformatf("result with none pending: %h", got));
         return;
      end
      want = centers_due.pop_front();
      if (got.center_x !== want.center_x) begin
         flag_error($sformatf("center_x got %0d want %0d", got.center_x, want.center_x));
      end
      if (got.center_y !== want.center_y) begin
         flag_error($sformatf("center_y got %0d want %0d", got.center_y, want.center_y));
      end
      if (got.radius !== want.radius) begin
         flag_error($sformatf("radius got %h want %h", got.radius, want.radius));
      end
   endtask

   // Result side: check every beat, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            check_center(rsp_data);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      bit hold_done;
      hold_done = 1'b0;
      error_count = 0;
      pixels_sent = 0;
      hold_left = 0;
      stall_left = 0;
      hold_request = 1'b0;
      idle_on = 1'b1;
      peak_now = '0;
      tie_total = '0;
      x_total = '0;
      y_total = '0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_ready <= 1'b0;

      // Single-pixel frames at both extremes.
      probes[0]  = mk(16'h0000, 0, 0, 1, 1, 0, 0, 16'h0000);
      probes[1]  = mk(16'hFFFF, 1023, 1023, 1, 1, 1023, 1023, 16'hFFFF);
      // A larger value restarts the group, an equal one joins it.
      probes[2]  = mk(16'h0010, 10, 20, 0, 0, 0, 0, 0);
      probes[3]  = mk(16'h0020, 4, 6, 0, 0, 0, 0, 0);
      probes[4]  = mk(16'h0020, 8, 10, 1, 1, 6, 8, 16'h0020);
      // Smaller values, the last pixel among them, are ignored.
      probes[5]  = mk(16'h0100, 100, 200, 0, 0, 0, 0, 0);
      probes[6]  = mk(16'h0080, 5, 5, 0, 0, 0, 0, 0);
      probes[7]  = mk(16'h0050, 0, 0, 1, 0, 0, 0, 0);
      // Ties at opposite corners after a restart.
      probes[8]  = mk(16'h0030, 1, 1, 0, 0, 0, 0, 0);
      probes[9]  = mk(16'h0030, 3, 3, 0, 0, 0, 0, 0);
      probes[10] = mk(16'h0040, 1023, 0, 0, 0, 0, 0, 0);
      probes[11] = mk(16'h0040, 0, 1023, 1, 0, 0, 0, 0);
      // Means that truncate.
      probes[12] = mk(16'h0005, 1, 0, 0, 0, 0, 0, 0);
      probes[13] = mk(16'h0005, 2, 0, 0, 0, 0, 0, 0);
      probes[14] = mk(16'h0005, 2, 1, 1, 0, 0, 0, 0);
      // A frame that never rises above zero.
      probes[15] = mk(16'h0000, 1023, 1023, 0, 0, 0, 0, 0);
      probes[16] = mk(16'h0000, 1022, 1022, 1, 1, 1022, 1022, 16'h0000);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_pixel(probes[i].px, probes[i].typed, probes[i].want);
      end

      // Sender pauses until the directed results have all come back.
      req_valid <= 1'b0;
      @(posedge clock);
      while (centers_due.size() != 0) @(posedge clock);

      while (pixels_sent < DIRECTED_ROWS + RANDOM_PIXELS) begin
         if (pixels_sent >= DIRECTED_ROWS + QUIET_FROM) begin
            idle_on = 1'b0;
         end else begin
            idle_on = ($urandom_range(0, 3) != 0);
         end
         // Long result-side hold while frames keep coming, to back up the input.
         if (!hold_done && pixels_sent >= DIRECTED_ROWS + HOLD_AT) begin
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         send_frame();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (centers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
